// ===== design/prl_pkg.sv =====
// Shared types and codes for the positional record list unit.
// Used by prl_ctrl and positional_record_list_unit; depends on nothing else.
package prl_pkg;

  localparam int ACCT_W   = 31;
  localparam int PIN_W    = 31;
  localparam int BAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_kind_t;

  // One stored record, kept as a single memory word.
  typedef struct packed {
    logic [ACCT_W-1:0]       acct;
    logic [PIN_W-1:0]        pin;
    logic signed [BAL_W-1:0] bal;
  } rec_t;

  typedef struct packed {
    req_kind_t        kind;
    logic [POS_W-1:0] pos;
    rec_t             rec;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [ACCT_W-1:0]    removed;
    logic [CNT_OUT_W-1:0] count;
  } reply_t;

endpackage

// ===== design/prl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the record store of the list unit.
module prl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/prl_ctrl.sv =====
// Sequencer and record store of the positional record list unit.
// Depends on prl_pkg and prl_ram.
module prl_ctrl import prl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  req_t   req,
  input  logic   out_free,
  output logic   idle,
  output logic   done,
  output reply_t reply
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_PLACE = 4'b0100,
    S_REPLY = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]     count;
  req_kind_t         kind;
  logic [POS_W-1:0]  pos;
  rec_t              rec;
  logic [CW-1:0]     ptr;
  logic              pend;
  logic              pend_cap;
  logic [AW-1:0]     pend_dst;
  status_t           status;
  logic [ACCT_W-1:0] removed;

  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_dec;
  logic          more;
  logic          is_ins;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;
  rec_t          rdata;

  logic [CMPW-1:0] req_pos_x;
  logic [CMPW-1:0] count_x;
  logic            bad_pos;
  logic            list_full;

  // Index step unit: one increment and one decrement of the sweep pointer.
  assign ptr_inc = ptr + 1'b1;
  assign ptr_dec = ptr - 1'b1;
  assign is_ins  = (kind == REQ_INSERT);

  // An insert sweeps down from the count to the position; a remove sweeps
  // up from the position to the count.
  assign more  = is_ins ? (CMPW'(ptr) > CMPW'(pos)) : (ptr < count);
  assign raddr = is_ins ? ptr_dec[AW-1:0] : ptr[AW-1:0];

  assign req_pos_x = CMPW'(req.pos);
  assign count_x   = CMPW'(count);
  assign bad_pos   = (req.kind == REQ_INSERT) ? (req_pos_x > count_x)
                                              : (req_pos_x >= count_x);
  assign list_full = (count == CW'(CAPACITY));

  always_comb begin
    we    = 1'b0;
    waddr = pend_dst;
    wdata = rdata;
    if (state == S_SHIFT && pend && !pend_cap) begin
      we = 1'b1;
    end else if (state == S_PLACE) begin
      we    = 1'b1;
      waddr = AW'(pos);
      wdata = rec;
    end
  end

  prl_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (bad_pos || (req.kind == REQ_INSERT && list_full)) begin
            state_next = S_REPLY;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (!more) begin
          state_next = is_ins ? S_PLACE : S_REPLY;
        end
      end
      S_PLACE: state_next = S_REPLY;
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_SHIFT && !more && !is_ins) begin
        count <= count - 1'b1;
      end else if (state == S_PLACE) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          kind    <= req.kind;
          pos     <= req.pos;
          rec     <= req.rec;
          removed <= '0;
          pend    <= 1'b0;
          ptr     <= (req.kind == REQ_INSERT) ? count : CW'(req.pos);
          if (bad_pos) begin
            status <= ST_RANGE;
          end else if (req.kind == REQ_INSERT && list_full) begin
            status <= ST_FULL;
          end else begin
            status <= ST_DONE;
          end
        end
      end
      S_SHIFT: begin
        pend     <= more;
        pend_cap <= !is_ins && (CMPW'(ptr) == CMPW'(pos));
        pend_dst <= is_ins ? ptr[AW-1:0] : ptr_dec[AW-1:0];
        if (more) begin
          ptr <= is_ins ? ptr_dec : ptr_inc;
        end
        if (pend && pend_cap) begin
          removed <= rdata.acct;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle          = (state == S_IDLE);
  assign done          = (state == S_REPLY) && out_free;
  assign reply.status  = status;
  assign reply.removed = removed;
  assign reply.count   = CNT_OUT_W'(count);

endmodule

// ===== design/positional_record_list_unit.sv =====
// Top level of the positional record list unit: request and reply channels.
// Depends on prl_pkg and prl_ctrl (which holds the prl_ram record store).
//
// The unit keeps an ordered list of up to CAPACITY account records (account
// number, pin, signed balance in cents) in one RAM with a registered read
// port. An insert beat places a record at a zero-based position and moves the
// entries at and after it up by one; a remove beat takes out the entry at a
// position, moves later entries down by one and reports its account number.
// A position past the list, or an insert into a full list, is rejected with
// a status code and leaves the list as it was; the position check comes
// first. Every request beat yields exactly one reply beat with the status,
// the removed account number (zero unless a remove succeeded) and the entry
// count afterwards. Entries are moved one per cycle through the single RAM
// port pair while the sequencer sweeps; an insert then writes the new record,
// and a rejected request goes straight to the reply. A receiver that holds
// the reply register full stalls the sequencer before it returns to idle.
// One request is in work at a time and in_ready is low meanwhile; the reply
// sits in an output register, and the next request is taken as soon as the
// reply has been handed over to it. Stored entries hold no value after
// reset; only entries below the count are ever used.
module positional_record_list_unit import prl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [POS_W-1:0]        position,
  input  logic [ACCT_W-1:0]       account_number,
  input  logic [PIN_W-1:0]        pin_code,
  input  logic signed [BAL_W-1:0] balance_cents,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic [ACCT_W-1:0]       removed_account,
  output logic [CNT_OUT_W-1:0]    entry_count
);

  req_t   req;
  reply_t reply;
  logic   idle;
  logic   done;
  logic   start;
  logic   out_free;

  // Pack the request beat for the sequencer; it latches it on start.
  assign req.kind     = req_kind_t'(req_type);
  assign req.pos      = position;
  assign req.rec.acct = account_number;
  assign req.rec.pin  = pin_code;
  assign req.rec.bal  = balance_cents;

  assign in_ready = idle;
  assign start    = in_valid && in_ready;

  // The reply register is free when empty or being drained this cycle.
  assign out_free = !out_valid || out_ready;

  prl_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .out_free(out_free),
    .idle    (idle),
    .done    (done),
    .reply   (reply)
  );

  // Output register: loaded only when the sequencer finishes and the slot is
  // free, so a waiting reply is never overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status          <= reply.status;
      removed_account <= reply.removed;
      entry_count     <= reply.count;
    end
  end

endmodule
